// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the RTL. They expand to
// nothing when the code is read by synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is held.
`define SLAL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Assertion that must hold at every edge, reset included.
`define SLAL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SLAL_ASSERT(name, clk, rst_n, prop, msg)
`define SLAL_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: hw/rtl/slal_pkg.sv
// ----------------------------------------------------------------------------
// slal_pkg
// Sizes, codes, types and width helpers for the shifting array list.
// ----------------------------------------------------------------------------
`default_nettype none

package slal_pkg;

    // Storage geometry.
    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W     = $clog2(DEPTH + 1);

    // Fixed field widths of the request and response.
    localparam int OP_W     = 3;
    localparam int POS_W    = 9;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int FOUND_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int CAP_W    = 9;
    localparam int CAP_RESET = 256;

    // Width used to compare positions, lengths and the capacity.
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef logic [WORD_BITS-1:0] word_t;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_APPEND = 3'd2,
        OP_READ   = 3'd3,
        OP_FIND   = 3'd4
    } op_t;

    // Response status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Edit broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        EDIT_HOLD   = 2'd0,
        EDIT_INSERT = 2'd1,
        EDIT_ERASE  = 2'd2,
        EDIT_APPEND = 2'd3
    } edit_kind_t;

    typedef struct packed {
        edit_kind_t       kind;
        logic [LEN_W-1:0] pos;
        word_t            word;
    } edit_t;

    // Search key held steady while a token runs down the chain.
    typedef struct packed {
        logic             mode_read;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] len;
        word_t            key;
    } search_t;

    // Token handed from cell to cell; the first matching cell fills it.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        word_t            word;
    } tok_t;

    // Status of the controller, watched by the top level.
    typedef struct packed {
        logic             scanning;
        logic [LEN_W-1:0] length;
    } ctrl_stat_t;

    // Width helpers.
    function automatic word_t value_to_word(input logic [VAL_W-1:0] v);
        logic [VAL_W+WORD_BITS-1:0] ext;
        ext = {{WORD_BITS{1'b0}}, v};
        return ext[WORD_BITS-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] word_to_value(input word_t w);
        logic [VAL_W+WORD_BITS-1:0] ext;
        ext = {{VAL_W{1'b0}}, w};
        return ext[VAL_W-1:0];
    endfunction

    function automatic logic [FOUND_W-1:0] idx_to_found(input logic [IDX_W-1:0] i);
        logic [FOUND_W+IDX_W-1:0] ext;
        ext = {{FOUND_W{1'b0}}, i};
        return ext[FOUND_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] len_to_cmp(input logic [LEN_W-1:0] l);
        return CMP_W'(l);
    endfunction

    function automatic logic [CMP_W-1:0] pos_to_cmp(input logic [POS_W-1:0] p);
        return CMP_W'(p);
    endfunction

    function automatic logic [CMP_W-1:0] cap_to_cmp(input logic [CAP_W-1:0] c);
        return CMP_W'(c);
    endfunction

    function automatic logic [LEN_W-1:0] cmp_to_len(input logic [CMP_W-1:0] c);
        return c[LEN_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] len_to_count(input logic [LEN_W-1:0] l);
        logic [COUNT_W+LEN_W-1:0] ext;
        ext = {{COUNT_W{1'b0}}, l};
        return ext[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/slal_cell.sv
// ----------------------------------------------------------------------------
// slal_cell
// One list entry: shifts with its neighbours on insert and erase, and
// passes the search token on by one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slal_cell import slal_pkg::*; (
    input  wire logic             aclk,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire edit_t            edit,
    input  wire search_t          search,
    input  wire word_t            left_word,
    input  wire word_t            right_word,
    output word_t                 word,
    input  wire tok_t             tok_in,
    output tok_t                  tok_out
);

    word_t            word_reg;
    word_t            word_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [LEN_W-1:0] my_idx;
    logic             match;

    assign my_idx = LEN_W'(cell_index);

    // Entry update: take the new word, the lower or the upper neighbour.
    always_comb begin
        word_next = word_reg;
        case (edit.kind)
            EDIT_INSERT: begin
                if (my_idx == edit.pos) begin
                    word_next = edit.word;
                end else if (my_idx > edit.pos) begin
                    word_next = left_word;
                end
            end
            EDIT_ERASE: begin
                if (my_idx >= edit.pos) begin
                    word_next = right_word;
                end
            end
            EDIT_APPEND: begin
                if (my_idx == edit.pos) begin
                    word_next = edit.word;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    // A read matches on its position, a find on the word within the list.
    always_comb begin
        if (search.mode_read) begin
            match = (my_idx == search.pos);
        end else begin
            match = (my_idx < search.len) && (word_reg == search.key);
        end
    end

    // The token keeps the first hit and is otherwise filled by this cell.
    always_comb begin
        tok_next = tok_in;
        if (!tok_in.hit && match) begin
            tok_next.hit  = 1'b1;
            tok_next.idx  = cell_index;
            tok_next.word = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        tok_reg  <= tok_next;
    end

    assign word    = word_reg;
    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: hw/rtl/slal_ctrl.sv
// ----------------------------------------------------------------------------
// slal_ctrl
// Request decoder, length and capacity registers, scan timer and the
// response register of the shifting array list.
// ----------------------------------------------------------------------------
`default_nettype none

module slal_ctrl import slal_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [OP_W-1:0]       req_op,
    input  wire logic [POS_W-1:0]      req_pos,
    input  wire logic [VAL_W-1:0]      req_value,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output status_t                    rsp_status,
    output logic [VAL_W-1:0]           rsp_read_value,
    output logic [FOUND_W-1:0]         rsp_found_index,
    output logic [COUNT_W-1:0]         rsp_count_after,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CAP_W-1:0]      cfg_wr_data,
    output edit_t                      edit,
    output search_t                    search,
    input  wire tok_t                  tok_last,
    output ctrl_stat_t                 stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    localparam logic [LEN_W-1:0] SCAN_LAST = LEN_W'(DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    state_t               state_reg,    state_next;
    logic [LEN_W-1:0]     len_reg,      len_next;
    logic [CAP_W-1:0]     cap_reg,      cap_next;
    logic [LEN_W-1:0]     cnt_reg,      cnt_next;
    logic                 mode_reg,     mode_next;
    logic [LEN_W-1:0]     spos_reg,     spos_next;
    word_t                key_reg,      key_next;
    logic                 ovalid_reg,   ovalid_next;
    status_t              ostat_reg,    ostat_next;
    logic [VAL_W-1:0]     ord_reg,      ord_next;
    logic [FOUND_W-1:0]   ofound_reg,   ofound_next;
    logic [LEN_W-1:0]     ocount_reg,   ocount_next;

    logic                 out_free;
    logic                 accept;
    logic [CMP_W-1:0]     pos_c;
    logic [CMP_W-1:0]     len_c;
    logic [CMP_W-1:0]     cap_c;
    logic [CMP_W-1:0]     eff_cap;
    logic                 is_full;

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tready && s_tvalid;

    // Position and capacity checks in a common width.
    assign pos_c   = pos_to_cmp(req_pos);
    assign len_c   = len_to_cmp(len_reg);
    assign cap_c   = cap_to_cmp(cap_reg);
    assign eff_cap = (cap_c > DEPTH_CMP) ? DEPTH_CMP : cap_c;
    assign is_full = (len_c >= eff_cap);

    // Configuration write.
    assign cap_next = cfg_wr_en ? cfg_wr_data : cap_reg;

    // Request decode, scan timing and response load.
    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        spos_next   = spos_reg;
        key_next    = key_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ostat_next  = ostat_reg;
        ord_next    = ord_reg;
        ofound_next = ofound_reg;
        ocount_next = ocount_reg;

        edit.kind = EDIT_HOLD;
        edit.pos  = cmp_to_len(pos_c);
        edit.word = value_to_word(req_value);

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Immediate response unless a scan is started below.
                    ovalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    ord_next    = '0;
                    ofound_next = '0;
                    case (op_t'(req_op))
                        OP_INSERT: begin
                            if (pos_c > len_c) begin
                                ostat_next = ST_BADPOS;
                            end else if (is_full) begin
                                ostat_next = ST_FULL;
                            end else begin
                                edit.kind = EDIT_INSERT;
                                len_next  = len_reg + LEN_W'(1);
                            end
                        end
                        OP_ERASE: begin
                            if (pos_c >= len_c) begin
                                ostat_next = ST_BADPOS;
                            end else begin
                                edit.kind = EDIT_ERASE;
                                len_next  = len_reg - LEN_W'(1);
                            end
                        end
                        OP_APPEND: begin
                            if (is_full) begin
                                ostat_next = ST_FULL;
                            end else begin
                                edit.kind = EDIT_APPEND;
                                edit.pos  = len_reg;
                                len_next  = len_reg + LEN_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (pos_c >= len_c) begin
                                ostat_next = ST_BADPOS;
                            end else begin
                                ovalid_next = ovalid_reg && !m_tready;
                                state_next  = S_SCAN;
                                cnt_next    = '0;
                                mode_next   = 1'b1;
                                spos_next   = cmp_to_len(pos_c);
                                key_next    = value_to_word(req_value);
                            end
                        end
                        OP_FIND: begin
                            ovalid_next = ovalid_reg && !m_tready;
                            state_next  = S_SCAN;
                            cnt_next    = '0;
                            mode_next   = 1'b0;
                            spos_next   = '0;
                            key_next    = value_to_word(req_value);
                        end
                        default: begin
                            ostat_next = ST_BADPOS;
                        end
                    endcase
                    ocount_next = len_next;
                end
            end
            S_SCAN: begin
                // The token has left the last cell once the count reaches DEPTH.
                if (cnt_reg == SCAN_LAST) begin
                    if (out_free) begin
                        ovalid_next = 1'b1;
                        ocount_next = len_reg;
                        ord_next    = '0;
                        ofound_next = '0;
                        if (!tok_last.hit) begin
                            ostat_next = ST_NOTFOUND;
                        end else begin
                            ostat_next = ST_OK;
                            if (mode_reg) begin
                                ord_next = word_to_value(tok_last.word);
                            end else begin
                                ofound_next = idx_to_found(tok_last.idx);
                            end
                        end
                        state_next = S_IDLE;
                    end
                end else begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            cap_reg    <= CAP_W'(CAP_RESET);
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            cap_reg    <= cap_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Search key and response payload.
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        spos_reg   <= spos_next;
        key_reg    <= key_next;
        ostat_reg  <= ostat_next;
        ord_reg    <= ord_next;
        ofound_reg <= ofound_next;
        ocount_reg <= ocount_next;
    end

    assign search.mode_read = mode_reg;
    assign search.pos       = spos_reg;
    assign search.len       = len_reg;
    assign search.key       = key_reg;

    assign m_tvalid        = ovalid_reg;
    assign rsp_status      = ostat_reg;
    assign rsp_read_value  = ord_reg;
    assign rsp_found_index = ofound_reg;
    assign rsp_count_after = len_to_count(ocount_reg);

    assign stat.scanning = (state_reg == S_SCAN);
    assign stat.length   = len_reg;

endmodule

`default_nettype wire

// File: hw/rtl/shifting_array_list_core.sv
// ----------------------------------------------------------------------------
// shifting_array_list_core
// Ordered list of signed words held in a chain of cells with a length count.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ channel: the operation in s_tuser, the position
// and the value in s_tdata. Each request gives exactly one response on the
// m_ channel: the status in m_tuser, the read word, the found index and the
// entry count after the request in m_tdata.
// Insert, erase, append and every rejected request finish without a scan:
// the response is valid the cycle after the request is taken, and while the
// receiver takes each response a new request can follow at once, so these run
// at one request per cycle. Read and find send a token along the chain of 256
// cells, one cell per cycle; the response is loaded once the token has left
// the last cell, and no request is taken while the token travels.
// The capacity register is written through cfg_wr_en and cfg_wr_data.
// Reset empties the list and sets the capacity to 256; the stored words
// themselves are not cleared and need no clearing pass.
// When the receiver stalls, the response waits in the output register and
// a further request is taken only once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module shifting_array_list_core import slal_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Request channel.
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,   // position[8:0], value[40:9], zeros
    input  wire logic [2:0]    s_tuser,   // operation[2:0]
    // Response channel.
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [55:0]        m_tdata,   // read_value[31:0], found_index[39:32],
                                          // count_after[48:40], zeros
    output logic [1:0]         m_tuser,   // status[1:0]
    // Capacity register.
    input  wire logic          cfg_wr_en,
    input  wire logic [8:0]    cfg_wr_data
);

    edit_t              edit;
    search_t            search;
    ctrl_stat_t         stat;
    status_t            rsp_status;
    logic [VAL_W-1:0]   rsp_read_value;
    logic [FOUND_W-1:0] rsp_found_index;
    logic [COUNT_W-1:0] rsp_count_after;
    word_t              cell_word [DEPTH];
    tok_t               cell_tok  [DEPTH];

    // Controller.
    slal_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .req_op          (s_tuser[2:0]),
        .req_pos         (s_tdata[8:0]),
        .req_value       (s_tdata[40:9]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .rsp_status      (rsp_status),
        .rsp_read_value  (rsp_read_value),
        .rsp_found_index (rsp_found_index),
        .rsp_count_after (rsp_count_after),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .edit            (edit),
        .search          (search),
        .tok_last        (cell_tok[DEPTH-1]),
        .stat            (stat)
    );

    // Chain of cells; each sees its two neighbours and the token behind it.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        word_t left_w;
        word_t right_w;
        tok_t  tin;

        if (g == 0) begin : g_first
            assign left_w = '0;
            assign tin    = '0;
        end else begin : g_inner
            assign left_w = cell_word[g-1];
            assign tin    = cell_tok[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_w = cell_word[g];
        end else begin : g_body
            assign right_w = cell_word[g+1];
        end

        slal_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(g)),
            .edit       (edit),
            .search     (search),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[g]),
            .tok_in     (tin),
            .tok_out    (cell_tok[g])
        );
    end

    // Response packing.
    assign m_tdata = {7'b0, rsp_count_after, rsp_found_index, rsp_read_value};
    assign m_tuser = rsp_status;

    // Checks.
    `SLAL_ASSERT(a_len_bound, aclk, aresetn, stat.length <= LEN_W'(DEPTH), "list length above depth")
    `SLAL_ASSERT(a_no_req_in_scan, aclk, aresetn, stat.scanning |-> !s_tready, "request taken during scan")
    `SLAL_ASSERT(a_scan_keeps_len, aclk, aresetn, stat.scanning |=> (stat.length == $past(stat.length)), "length changed during scan")
    `SLAL_ASSERT(a_found_needs_ok, aclk, aresetn, (m_tvalid && (m_tdata[39:32] != 8'd0)) |-> (m_tuser == ST_OK), "index given without ok status")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shifting array list core. Each accepted request
// is run through a local predictor of the list. Responses are checked field
// by field, in order. Directed edge cases come first. Several random phases
// under different capacities follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import slal_pkg::*;;

    // Operation codes that the block must reject.
    localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

    // Cycles with no handshake on either channel before the run is abandoned.
    localparam int QUIET_LIMIT    = 2000;
    // Receiver hold-off used to back the block up into its request channel.
    localparam int HOLD_OFF       = 120;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 120;

    localparam logic [CAP_W-1:0] PHASE_CAPACITY [RANDOM_PHASES] =
        '{9'd256, 9'd1, 9'd12, 9'd300, 9'd40, 9'd0, 9'd511, 9'd3};
    localparam int PHASE_GROWTH [RANDOM_PHASES] = '{45, 40, 50, 70, 45, 40, 30, 50};

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VAL_W-1:0]   read_value;
        logic [FOUND_W-1:0] found_index;
        logic [COUNT_W-1:0] count_after;
    } list_response_t;

    // Shadow copy of the list plus the queue of responses still owed by the block.
    class list_scoreboard;
        word_t            entries [DEPTH];
        int unsigned      length;
        logic [CAP_W-1:0] capacity;
        list_response_t   expected [$];
        int unsigned      errors;

        function new();
            length   = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function int unsigned room();
            return (capacity > DEPTH) ? DEPTH : capacity;
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

        // Apply one accepted request to the shadow list and queue its response.
        function void note_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input logic [VAL_W-1:0] val);
            list_response_t resp;
            int unsigned    p;
            int unsigned    i;
            word_t          w;
            logic           hit;
            resp = '0;
            resp.status = ST_OK;
            p = pos;
            w = val[WORD_BITS-1:0];
            hit = 1'b0;
            case (op)
                OP_INSERT: begin
                    if (p > length) begin
                        resp.status = ST_BADPOS;
                    end else if (length >= room()) begin
                        resp.status = ST_FULL;
                    end else begin
                        for (i = length; i > p; i--) entries[i] = entries[i-1];
                        entries[p] = w;
                        length++;
                    end
                end
                OP_ERASE: begin
                    if (p >= length) begin
                        resp.status = ST_BADPOS;
                    end else begin
                        for (i = p; i + 1 < length; i++) entries[i] = entries[i+1];
                        length--;
                    end
                end
                OP_APPEND: begin
                    if (length >= room()) begin
                        resp.status = ST_FULL;
                    end else begin
                        entries[length] = w;
                        length++;
                    end
                end
                OP_READ: begin
                    if (p >= length) resp.status = ST_BADPOS;
                    else resp.read_value = VAL_W'(entries[p]);
                end
                OP_FIND: begin
                    // The lowest matching index wins.
                    for (i = 0; i < length; i++) begin
                        if (!hit && entries[i] == w) begin
                            hit = 1'b1;
                            resp.found_index = FOUND_W'(i);
                        end
                    end
                    if (!hit) resp.status = ST_NOTFOUND;
                end
                default: begin
                    resp.status = ST_BADPOS;
                end
            endcase
            resp.count_after = COUNT_W'(length);
            expected.push_back(resp);
        endfunction

        // Compare one accepted response with the oldest one owed.
        function void check_response(input logic [STAT_W-1:0] status,
                                     input logic [VAL_W-1:0] read_value,
                                     input logic [FOUND_W-1:0] found_index,
                                     input logic [COUNT_W-1:0] count_after);
            list_response_t want;
            if (expected.size() == 0) begin
                $error("response with no request outstanding: status %0d, count_after %0d",
                       status, count_after);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %h, actual %h", want.read_value, read_value);
                errors++;
            end
            if (found_index !== want.found_index) begin
                $error("found_index: expected %0d, actual %0d", want.found_index, found_index);
                errors++;
            end
            if (count_after !== want.count_after) begin
                $error("count_after: expected %0d, actual %0d", want.count_after, count_after);
                errors++;
            end
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata     = '0;   // position[8:0], value[40:9], zeros
    logic [OP_W-1:0]   s_tuser     = '0;   // operation[2:0]
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [55:0]       m_tdata;            // read_value[31:0], found_index[39:32],
                                           // count_after[48:40], zeros
    logic [STAT_W-1:0] m_tuser;            // status[1:0]
    logic              cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;

    list_scoreboard sb;
    int unsigned    sender_calm  = 0;
    int unsigned    quiet_cycles = 0;

    always #2 aclk = ~aclk;

    shifting_array_list_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int unsigned gap;
        if (sender_calm > 0) begin
            gap = 0;
            sender_calm--;
        end else begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 19) == 0) sender_calm = 40;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, val, pos};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, pos, val);
        @(negedge aclk);
    endtask

    // Build a random request against the current shadow list.
    task automatic send_random_request(input int unsigned growth_pct);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int unsigned      roll;
        int unsigned      len;
        len  = sb.length;
        roll = $urandom_range(0, 99);
        if (roll >= 97) begin
            op = OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
        end else if (roll < growth_pct) begin
            op = ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    op = OP_READ;
                end
                1: begin
                    op = OP_FIND;
                end
                default: begin
                    op = OP_ERASE;
                end
            endcase
        end

        // Mostly legal positions, with some noise across the whole field.
        if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 511));
        else if (op == OP_INSERT) pos = POS_W'($urandom_range(0, len));
        else if (len > 0) pos = POS_W'($urandom_range(0, len - 1));
        else pos = '0;

        // Finds mostly look for a stored word; a small pool of values makes duplicates.
        roll = $urandom_range(0, 19);
        if (op == OP_FIND && len > 0 && roll < 12) begin
            val = VAL_W'(sb.entries[$urandom_range(0, len - 1)]);
        end else if (roll < 13) begin
            val = $urandom();
        end else if (roll < 18) begin
            val = VAL_W'($urandom_range(0, 7));
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    val = 32'h8000_0000;
                end
                1: begin
                    val = 32'h7FFF_FFFF;
                end
                2: begin
                    val = '1;
                end
                default: begin
                    val = '0;
                end
            endcase
        end
        send_request(op, pos, val);
    endtask

    // Stop offering requests, wait for every owed response, then let the block settle.
    task automatic wait_until_drained(input int unsigned settle_cycles);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (settle_cycles) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.capacity = limit;
    endtask

    // Response side: random stalls, quiet stretches, and two long hold-offs.
    initial begin
        int unsigned stall;
        int unsigned calm;
        int unsigned taken;
        calm  = 0;
        taken = 0;
        @(posedge aresetn);
        forever begin
            if (taken == 40 || taken == 900) begin
                stall = HOLD_OFF;
            end else if (calm > 0) begin
                stall = 0;
                calm--;
            end else begin
                stall = $urandom_range(0, 15);
                if ($urandom_range(0, 19) == 0) calm = 40;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            @(negedge aclk);
        end
    end

    // Check every response taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_response(m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[48:40]);
        end
    end

    // Give up when neither channel has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned code;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty list: every position is out of range and nothing is found.
        send_request(OP_READ,   9'd0, 32'd0);
        send_request(OP_ERASE,  9'd0, 32'd0);
        send_request(OP_FIND,   9'd0, 32'd0);
        send_request(OP_INSERT, 9'd1, 32'd1);
        // Build a short list holding the extreme words.
        send_request(OP_INSERT, 9'd0, 32'h8000_0000);
        send_request(OP_APPEND, 9'd0, 32'h7FFF_FFFF);
        send_request(OP_APPEND, 9'd511, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 9'd3, 32'h0000_0000);
        send_request(OP_INSERT, 9'd1, 32'h5555_AAAA);
        send_request(OP_APPEND, 9'd0, 32'hFFFF_FFFF);
        // Reads at the first and last entry and just past the end.
        send_request(OP_READ,   9'd0, 32'd0);
        send_request(OP_READ,   9'd5, 32'd0);
        send_request(OP_READ,   9'd6, 32'd0);
        send_request(OP_READ,   9'd511, 32'hFFFF_FFFF);
        // A duplicated word must give its first index.
        send_request(OP_FIND,   9'd0, 32'hFFFF_FFFF);
        send_request(OP_FIND,   9'd0, 32'h0000_0000);
        send_request(OP_FIND,   9'd0, 32'h1234_5678);
        // Erase at the head and at the tail, then out of range.
        send_request(OP_ERASE,  9'd0, 32'd0);
        send_request(OP_ERASE,  9'd4, 32'd0);
        send_request(OP_ERASE,  9'd256, 32'd0);
        send_request(OP_INSERT, 9'd511, 32'd0);
        for (code = OP_UNKNOWN_FIRST; code <= OP_UNKNOWN_LAST; code++) begin
            send_request(OP_W'(code), 9'd511, 32'hFFFF_FFFF);
        end
        send_request(OP_FIND,   9'd0, 32'h8000_0000);
        wait_until_drained(8);

        // Capacity lowered below the length: a bad position still wins over full.
        write_capacity(9'd2);
        send_request(OP_INSERT, 9'd5, 32'd7);
        send_request(OP_INSERT, 9'd0, 32'd7);
        send_request(OP_APPEND, 9'd0, 32'd7);
        send_request(OP_READ,   9'd3, 32'd0);
        send_request(OP_ERASE,  9'd3, 32'd0);
        wait_until_drained(8);

        // Zero capacity: nothing can be added.
        write_capacity(9'd0);
        send_request(OP_APPEND, 9'd0, 32'd9);
        send_request(OP_INSERT, 9'd0, 32'd9);
        send_request(OP_FIND,   9'd0, 32'h7FFF_FFFF);
        wait_until_drained(8);

        // Capacity above the depth: fill every cell, then look at the last one.
        write_capacity(9'd511);
        while (sb.length < DEPTH) begin
            send_request(OP_APPEND, POS_W'($urandom_range(0, 511)), $urandom());
        end
        send_request(OP_APPEND, 9'd0, 32'd1);
        send_request(OP_INSERT, 9'd256, 32'd1);
        send_request(OP_INSERT, 9'd257, 32'd1);
        send_request(OP_READ,   9'd255, 32'd0);
        send_request(OP_FIND,   9'd0, VAL_W'(sb.entries[DEPTH-1]));
        send_request(OP_READ,   9'd0, 32'd0);
        while (sb.length > 0) begin
            send_request(OP_ERASE, POS_W'($urandom_range(0, sb.length - 1)), $urandom());
        end
        wait_until_drained(8);

        // Random phases, each under its own capacity and growth bias.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_capacity(PHASE_CAPACITY[phase]);
            repeat (PHASE_REQUESTS) send_random_request(PHASE_GROWTH[phase]);
            wait_until_drained(8);
        end

        wait_until_drained(300);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/slal_pkg.sv
hw/rtl/slal_cell.sv
hw/rtl/slal_ctrl.sv
hw/rtl/shifting_array_list_core.sv
tb/tb_top.sv
